// File: hdl/calorimeter_cell_neighborhood_assert.svh
// Assertion macros for the calorimeter cell neighborhood block.
// Included by the modules that check their own control logic; no other dependencies.
`ifndef CALORIMETER_CELL_NEIGHBORHOOD_ASSERT_SVH
`define CALORIMETER_CELL_NEIGHBORHOOD_ASSERT_SVH
`ifndef SYNTHESIS
`define CCN_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CCN_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CCN_ASSERT(label, clk, rst_n, prop, msg)
`define CCN_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/ccn_pkg.sv
// Shared types, constants and the module layout table of the cell neighborhood block.
// No dependencies; used by every module of the block.
package ccn_pkg;

  localparam int CCN_NUM_CELLS        = 17664;
  localparam int CCN_NUM_MODULES      = 20;
  localparam int CCN_MAX_WINDOW       = 7;
  localparam int CCN_QUEUE_DEPTH      = 2;

  localparam int CCN_FULL_CELLS       = 1152;
  localparam int CCN_NARROW_CELLS     = 384;
  localparam int CCN_TWO_THIRDS_CELLS = 768;
  localparam int CCN_THIRD_BASE       = 11520;
  localparam int CCN_TWO_THIRDS_BASE  = 12288;
  localparam int CCN_TAIL_BASE        = 16896;

  localparam int CCN_CFG_IDX_W  = 2;
  localparam int CCN_CFG_DATA_W = 5;
  localparam logic [CCN_CFG_IDX_W-1:0] CCN_REG_WINDOW_SIZE = 2'd0;
  localparam logic [CCN_CFG_IDX_W-1:0] CCN_REG_EDGE_MARGIN = 2'd1;

  // One classified cell as it waits between the front and back ends.
  typedef struct packed {
    logic [14:0] cell_id;
    logic [4:0]  sm;
    logic [5:0]  eta;
    logic [4:0]  phi;
    logic        np24;
    logic        margin_ok;
    logic        id_error;
  } ccn_item_t;

  typedef struct packed {
    logic [2:0] win_last;
    logic [4:0] edge_margin;
  } ccn_cfg_t;

  // First global cell number of each module.
  function automatic logic [14:0] ccn_module_start(input logic [4:0] sm);
    logic [14:0] start;
    if (sm < 5'd10) begin
      start = 15'(int'(sm) * CCN_FULL_CELLS);
    end else if (sm < 5'd12) begin
      start = 15'(CCN_THIRD_BASE + (int'(sm) - 10) * CCN_NARROW_CELLS);
    end else if (sm < 5'd18) begin
      start = 15'(CCN_TWO_THIRDS_BASE + (int'(sm) - 12) * CCN_TWO_THIRDS_CELLS);
    end else begin
      start = 15'(CCN_TAIL_BASE + (int'(sm) - 18) * CCN_NARROW_CELLS);
    end
    return start;
  endfunction

endpackage

// File: hdl/calorimeter_cell_neighborhood.sv
// Top level of the calorimeter cell neighborhood block: configuration registers and wiring
// of front end, item queue and back end. Depends on ccn_pkg, ccn_front, ccn_queue, ccn_back.
//
// Each accepted cell id yields m*m results, one per cycle unless out_stall holds them,
// row by row, where m is the window size (0 reads as 1; data bits above bit 2 are
// dropped); an id beyond the last cell yields one result with id_error set. The window
// sequencer in the back end emits one neighbor id per cycle while the output is not
// stalled and sets the sustained rate. The front end decodes in two pipeline stages and
// accepts a new id every cycle while the queue has room, so decoding overlaps the window
// walk of earlier cells. An accepted cell passes both decode stages, the item queue and
// the back end item register before its first result is registered at the output.
// Configuration writes are always taken and must only be made while the block is idle.
module calorimeter_cell_neighborhood #(
  parameter int QUEUE_DEPTH = ccn_pkg::CCN_QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [14:0]                           in_cell_id,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [15:0]                    out_neighbor_id,
  output logic [2:0]                            out_window_row,
  output logic [2:0]                            out_window_col,
  output logic [4:0]                            out_supermodule,
  output logic [5:0]                            out_eta_index,
  output logic [4:0]                            out_phi_index,
  output logic                                  out_margin_ok,
  output logic                                  out_id_error,
  output logic                                  out_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ccn_pkg::CCN_CFG_IDX_W-1:0]     cfg_index,
  input  logic [ccn_pkg::CCN_CFG_DATA_W-1:0]    cfg_data
);
  import ccn_pkg::*;

  logic [2:0] window_size_r;
  logic [4:0] edge_margin_r;
  logic [3:0] win_m;
  ccn_cfg_t   cfg;

  logic       push, full, pop, q_valid;
  ccn_item_t  push_item, q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= 3'd5;
      edge_margin_r <= 5'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CCN_REG_WINDOW_SIZE: window_size_r <= cfg_data[2:0];
        CCN_REG_EDGE_MARGIN: edge_margin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (window_size_r == 3'd0) begin
      win_m = 4'd1;
    end else if ({1'b0, window_size_r} > 4'(CCN_MAX_WINDOW)) begin
      win_m = 4'(CCN_MAX_WINDOW);
    end else begin
      win_m = {1'b0, window_size_r};
    end
    cfg.win_last    = 3'(win_m - 4'd1);
    cfg.edge_margin = edge_margin_r;
  end

  ccn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cell_id (in_cell_id),
    .cfg_i      (cfg),
    .push_o     (push),
    .item_o     (push_item),
    .full_i     (full)
  );

  ccn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  ccn_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_i           (cfg),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .pop_o           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_neighbor_id (out_neighbor_id),
    .out_window_row  (out_window_row),
    .out_window_col  (out_window_col),
    .out_supermodule (out_supermodule),
    .out_eta_index   (out_eta_index),
    .out_phi_index   (out_phi_index),
    .out_margin_ok   (out_margin_ok),
    .out_id_error    (out_id_error),
    .out_last        (out_last)
  );

endmodule

// File: hdl/ccn_front.sv
// Front end: accepts cell ids and decodes module, eta, phi and the edge flag in two stages.
// Depends on ccn_pkg; feeds the item queue.
module ccn_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [14:0]         in_cell_id,
  input  ccn_pkg::ccn_cfg_t   cfg_i,
  output logic                push_o,
  output ccn_pkg::ccn_item_t  item_o,
  input  logic                full_i
);
  import ccn_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic [14:0] s1_id_r;
  logic        s2_valid_r, s2_valid_nxt;
  logic [14:0] s2_id_r;
  logic        s2_err_r;
  logic [4:0]  s2_sm_r;
  logic [10:0] s2_rel_r;

  logic        s1_en, s2_en;
  logic        dec_err;
  logic [4:0]  dec_sm;
  logic [14:0] dec_diff;

  logic        np24, neta32;
  logic [6:0]  rel_hi;
  logic [12:0] prod;
  logic [4:0]  q;
  logic [9:0]  phi24;
  logic [5:0]  eta;
  logic [4:0]  phi;
  logic [6:0]  d7;
  logic [6:0]  neta7, nphi7;
  logic        margin_ok;

  assign s2_en    = !s2_valid_r || !full_i;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_stall = !s1_en;
  assign push_o   = s2_valid_r && !full_i;

  // Module number: the last module whose first cell is not above the id.
  always_comb begin
    dec_err = (s1_id_r >= 15'(CCN_NUM_CELLS));
    dec_sm  = '0;
    for (int k = 1; k < CCN_NUM_MODULES; k++) begin
      if (s1_id_r >= ccn_module_start(5'(k))) begin
        dec_sm = 5'(k);
      end
    end
    dec_diff = s1_id_r - ccn_module_start(dec_sm);
  end

  assign s1_valid_nxt = s1_en ? in_valid : s1_valid_r;
  assign s2_valid_nxt = s2_en ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_id_r <= in_cell_id;
    end
    if (s2_en) begin
      s2_id_r  <= s1_id_r;
      s2_err_r <= dec_err;
      s2_sm_r  <= dec_sm;
      s2_rel_r <= dec_diff[10:0];
    end
  end

  // Pairs of cells run along phi, so rel / (2 * nphi) is the eta pair and (rel / 2) % nphi
  // the phi column. For 24 columns the division by 48 is a shift by four and a
  // multiply-by-43 reciprocal, exact for the quotients that occur here.
  always_comb begin
    np24      = !(s2_sm_r inside {5'd10, 5'd11, 5'd18, 5'd19});
    neta32    = (s2_sm_r inside {[5'd12:5'd17]});
    rel_hi    = s2_rel_r[10:4];
    prod      = 13'(rel_hi) * 13'd43;
    q         = np24 ? prod[11:7] : rel_hi[4:0];
    phi24     = s2_rel_r[10:1] - 10'({q, 4'b0000}) - 10'({q, 3'b000});
    phi       = np24 ? phi24[4:0] : {2'b00, s2_rel_r[3:1]};
    eta       = {q, ~s2_rel_r[0]};
    d7        = {2'b00, cfg_i.edge_margin};
    neta7     = neta32 ? 7'd32 : 7'd48;
    nphi7     = np24 ? 7'd24 : 7'd8;
    margin_ok = ({1'b0, eta} >= d7) && ({2'b00, phi} >= d7) &&
                (({1'b0, eta} + d7) < neta7) && (({2'b00, phi} + d7) < nphi7);
  end

  always_comb begin
    item_o = '0;
    if (s2_err_r) begin
      item_o.id_error = 1'b1;
    end else begin
      item_o.cell_id   = s2_id_r;
      item_o.sm        = s2_sm_r;
      item_o.eta       = eta;
      item_o.phi       = phi;
      item_o.np24      = np24;
      item_o.margin_ok = margin_ok;
    end
  end

endmodule

// File: hdl/ccn_queue.sv
// Short first-word-fall-through queue of classified cells between front and back ends.
// Depends on ccn_pkg for the item type and on the assertion macro header.
module ccn_queue #(
  parameter int DEPTH = ccn_pkg::CCN_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  ccn_pkg::ccn_item_t  item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output ccn_pkg::ccn_item_t  item_o
);
  import ccn_pkg::*;
  `include "calorimeter_cell_neighborhood_assert.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ccn_item_t     mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] ptr);
    logic [PW-1:0] res;
    if (ptr == PW'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PW'(1);
    end
    return res;
  endfunction

  assign full_o  = (count_r == CW'(DEPTH));
  assign valid_o = (count_r != '0);
  assign item_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop_i ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push_i && !pop_i) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= item_i;
    end
  end

  `CCN_ASSERT(a_no_overflow, clk, rst_n, !(push_i && full_o), "push into a full queue")
  `CCN_ASSERT(a_no_underflow, clk, rst_n, !(pop_i && !valid_o), "pop from an empty queue")
  `CCN_ASSERT(a_count_range, clk, rst_n, count_r <= CW'(DEPTH), "queue count beyond depth")

endmodule

// File: hdl/ccn_back.sv
// Back end: walks the neighbor window of each queued cell and drives the result register.
// Depends on ccn_pkg for the item and configuration types and on the assertion macro header.
module ccn_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ccn_pkg::ccn_cfg_t   cfg_i,
  input  logic                q_valid_i,
  input  ccn_pkg::ccn_item_t  q_item_i,
  output logic                pop_o,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_neighbor_id,
  output logic [2:0]          out_window_row,
  output logic [2:0]          out_window_col,
  output logic [4:0]          out_supermodule,
  output logic [5:0]          out_eta_index,
  output logic [4:0]          out_phi_index,
  output logic                out_margin_ok,
  output logic                out_id_error,
  output logic                out_last
);
  import ccn_pkg::*;
  `include "calorimeter_cell_neighborhood_assert.svh"

  logic       busy_r, busy_nxt;
  ccn_item_t  item_r;
  logic [2:0] row_r, col_r;
  logic       out_valid_r, out_valid_nxt;
  logic signed [15:0] out_id_r;
  logic [2:0] out_row_r, out_col_r;
  logic [4:0] out_sm_r;
  logic [5:0] out_eta_r;
  logic [4:0] out_phi_r;
  logic       out_margin_r, out_err_r, out_last_r;

  logic       load_en, pos_last, advance;
  logic [2:0] half;
  logic signed [4:0]  ic, icp;
  logic               odd_row, n_even;
  logic signed [15:0] icp_ext, roff, coff, nid;

  assign load_en  = !out_valid_r || !out_stall;
  assign pos_last = item_r.id_error || (row_r == cfg_i.win_last && col_r == cfg_i.win_last);
  assign pop_o    = load_en && (!busy_r || pos_last) && q_valid_i;
  assign advance  = load_en && busy_r && !pos_last;

  // Odd rows sit in the other half of a cell pair, so they shift by one pair of rows, toward
  // higher rows for an even center cell and lower rows for an odd one, and by one cell along the pair.
  always_comb begin
    half    = {1'b0, cfg_i.win_last[2:1]};
    ic      = $signed({2'b00, row_r}) - $signed({2'b00, half});
    odd_row = ic[0];
    n_even  = !item_r.cell_id[0];
    if (!odd_row) begin
      icp = ic;
    end else if (n_even) begin
      icp = ic + 5'sd1;
    end else begin
      icp = ic - 5'sd1;
    end
    icp_ext = 16'(icp);
    roff    = item_r.np24 ? ((icp_ext <<< 4) + (icp_ext <<< 3)) : (icp_ext <<< 3);
    if (odd_row) begin
      roff = n_even ? (roff + 16'sd1) : (roff - 16'sd1);
    end
    coff = $signed({12'd0, col_r, 1'b0}) - $signed({13'd0, cfg_i.win_last});
    nid  = $signed({1'b0, item_r.cell_id}) + roff + coff;
    if (item_r.id_error) begin
      nid = '0;
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (load_en) begin
      out_valid_nxt = busy_r;
      busy_nxt      = (busy_r && !pos_last) || q_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      item_r <= q_item_i;
      row_r  <= '0;
      col_r  <= '0;
    end else if (advance) begin
      if (col_r == cfg_i.win_last) begin
        col_r <= '0;
        row_r <= row_r + 3'd1;
      end else begin
        col_r <= col_r + 3'd1;
      end
    end
    if (load_en && busy_r) begin
      out_id_r     <= nid;
      out_row_r    <= row_r;
      out_col_r    <= col_r;
      out_sm_r     <= item_r.sm;
      out_eta_r    <= item_r.eta;
      out_phi_r    <= item_r.phi;
      out_margin_r <= item_r.margin_ok;
      out_err_r    <= item_r.id_error;
      out_last_r   <= pos_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_neighbor_id = out_id_r;
  assign out_window_row  = out_row_r;
  assign out_window_col  = out_col_r;
  assign out_supermodule = out_sm_r;
  assign out_eta_index   = out_eta_r;
  assign out_phi_index   = out_phi_r;
  assign out_margin_ok   = out_margin_r;
  assign out_id_error    = out_err_r;
  assign out_last        = out_last_r;

  `CCN_IMPLY(a_window_unbroken, clk, rst_n, out_valid_r && !out_stall && !out_last_r,
             out_valid_r, "gap inside a neighbor window")
  `CCN_ASSERT(a_error_single, clk, rst_n, !(out_valid_r && out_err_r) || out_last_r,
              "error result not marked last")
  `CCN_ASSERT(a_pos_in_window, clk, rst_n,
              !out_valid_r || (out_row_r <= cfg_i.win_last && out_col_r <= cfg_i.win_last),
              "window position beyond configured size")

endmodule

// File: tb/sv/calorimeter_cell_neighborhood_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the calorimeter cell neighborhood block: a queue-fed driver
// that feeds a window predictor, a result monitor, and idle-cycle timeout.
// Depends on ccn_pkg and the calorimeter_cell_neighborhood RTL.
module calorimeter_cell_neighborhood_test;
  import ccn_pkg::*;

  localparam logic [CCN_CFG_IDX_W-1:0] REG_SPARE_LOW  = 2'd2;
  localparam logic [CCN_CFG_IDX_W-1:0] REG_SPARE_HIGH = 2'd3;
  localparam int IDLE_LIMIT     = 3000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_PHASES  = 6;
  localparam int CELLS_PER_PHASE = 13;

  typedef struct packed {
    logic signed [15:0] neighbor_id;
    logic [2:0]         window_row;
    logic [2:0]         window_col;
    logic [4:0]         supermodule;
    logic [5:0]         eta_index;
    logic [4:0]         phi_index;
    logic               margin_ok;
    logic               id_error;
    logic               last;
  } window_cell_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [14:0] in_cell_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_neighbor_id;
  logic [2:0] out_window_row;
  logic [2:0] out_window_col;
  logic [4:0] out_supermodule;
  logic [5:0] out_eta_index;
  logic [4:0] out_phi_index;
  logic out_margin_ok;
  logic out_id_error;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CCN_CFG_IDX_W-1:0] cfg_index = '0;
  logic [CCN_CFG_DATA_W-1:0] cfg_data = '0;

  // Register copies used for prediction, at their reset values.
  logic [2:0] win_setting = 3'd5;
  logic [4:0] margin_setting = 5'd2;

  logic [14:0] cell_queue[$];
  window_cell_t expected_cells[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int mode_left = 0;
  bit hold_request = 1'b0;
  stall_style_t stall_mode = STALL_NONE;

  calorimeter_cell_neighborhood dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cell_id(in_cell_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_neighbor_id(out_neighbor_id), .out_window_row(out_window_row),
    .out_window_col(out_window_col), .out_supermodule(out_supermodule),
    .out_eta_index(out_eta_index), .out_phi_index(out_phi_index),
    .out_margin_ok(out_margin_ok), .out_id_error(out_id_error), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Decodes a cell number and queues the whole neighbor window it should produce.
  function automatic void predict_window(input logic [14:0] cell_num);
    int num, sm, base, nphi, neta, rel, eta, phi, d, m, half, ic, roff, coff, id;
    window_cell_t w;
    num = int'(cell_num);
    w = '0;
    if (num >= CCN_NUM_CELLS) begin
      w.id_error = 1'b1;
      w.last = 1'b1;
      expected_cells = {expected_cells, w};
      return;
    end
    if (num < CCN_THIRD_BASE) begin
      sm = num / CCN_FULL_CELLS;
      base = sm * CCN_FULL_CELLS;
      nphi = 24;
      neta = 48;
    end else if (num < CCN_TWO_THIRDS_BASE) begin
      sm = 10 + (num - CCN_THIRD_BASE) / CCN_NARROW_CELLS;
      base = CCN_THIRD_BASE + (sm - 10) * CCN_NARROW_CELLS;
      nphi = 8;
      neta = 48;
    end else if (num < CCN_TAIL_BASE) begin
      sm = 12 + (num - CCN_TWO_THIRDS_BASE) / CCN_TWO_THIRDS_CELLS;
      base = CCN_TWO_THIRDS_BASE + (sm - 12) * CCN_TWO_THIRDS_CELLS;
      nphi = 24;
      neta = 32;
    end else begin
      sm = 18 + (num - CCN_TAIL_BASE) / CCN_NARROW_CELLS;
      base = CCN_TAIL_BASE + (sm - 18) * CCN_NARROW_CELLS;
      nphi = 8;
      neta = 48;
    end
    rel = num - base;
    // Pairs run along phi; the odd member of a pair sits in the lower eta row.
    eta = 2 * (rel / (2 * nphi)) + 1 - (rel % 2);
    phi = (rel / 2) % nphi;
    d = int'(margin_setting);
    w.supermodule = sm[4:0];
    w.eta_index = eta[5:0];
    w.phi_index = phi[4:0];
    w.margin_ok = (eta >= d && phi >= d && eta + d < neta && phi + d < nphi);
    m = (win_setting == 3'd0) ? 1 : int'(win_setting);
    if (m > CCN_MAX_WINDOW) m = CCN_MAX_WINDOW;
    half = (m - 1) / 2;
    for (int r = 0; r < m; r++) begin
      ic = r - half;
      if ((ic & 1) == 0) roff = ic * nphi;
      else if (num % 2 == 0) roff = (ic + 1) * nphi + 1;
      else roff = (ic - 1) * nphi - 1;
      for (int c = 0; c < m; c++) begin
        coff = 2 * c - (m - 1);
        id = num + roff + coff;
        w.neighbor_id = id[15:0];
        w.window_row = r[2:0];
        w.window_col = c[2:0];
        w.last = (r == m - 1 && c == m - 1);
        expected_cells = {expected_cells, w};
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [5:0] want,
                                      input logic [5:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Sender: bursts of random length separated by random gaps; payload held while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_window(cell_queue.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cell_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_cell_id <= cell_queue[0];
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer and stalls on its own pattern.
  always @(posedge clk) begin : receiver
    window_cell_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          $error("result with nothing expected: neighbor_id %0d, id_error %0b",
                 out_neighbor_id, out_id_error);
          mismatch_count++;
        end else begin
          want = expected_cells.pop_front();
          if (out_neighbor_id !== want.neighbor_id) begin
            $error("neighbor_id: expected %0d, got %0d", want.neighbor_id, out_neighbor_id);
            mismatch_count++;
          end
          check_field("window_row", 6'(want.window_row), 6'(out_window_row));
          check_field("window_col", 6'(want.window_col), 6'(out_window_col));
          check_field("supermodule", 6'(want.supermodule), 6'(out_supermodule));
          check_field("eta_index", want.eta_index, out_eta_index);
          check_field("phi_index", 6'(want.phi_index), 6'(out_phi_index));
          check_field("margin_ok", 6'(want.margin_ok), 6'(out_margin_ok));
          check_field("id_error", 6'(want.id_error), 6'(out_id_error));
          check_field("last", 6'(want.last), 6'(out_last));
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_style_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 60);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Timeout on a run of cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CCN_CFG_IDX_W-1:0] idx,
                           input logic [CCN_CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CCN_REG_WINDOW_SIZE: win_setting = data[2:0];
      CCN_REG_EDGE_MARGIN: margin_setting = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (cell_queue.size() != 0 || expected_cells.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [14:0] pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: module boundaries, pair parity, edge cells and ids past the end.
    cell_queue = '{15'd0, 15'd1, 15'd47, 15'd577, 15'd1151, 15'd1152, 15'd11519,
                   15'd11520, 15'd11904, 15'd12287, 15'd12288, 15'd13055, 15'd16895,
                   15'd16896, 15'd17663, 15'd17664, 15'd32767};
    wait_drained();
    // A zero window reads as one; a margin no cell can keep.
    write_reg(CCN_REG_WINDOW_SIZE, 5'd0);
    write_reg(CCN_REG_EDGE_MARGIN, 5'd31);
    cfg_valid <= 1'b0;
    cell_queue = '{15'd600, 15'd17664, 15'd7};
    wait_drained();
    // Upper data bits are dropped, leaving an even window; zero margin.
    write_reg(CCN_REG_WINDOW_SIZE, 5'd30);
    write_reg(CCN_REG_EDGE_MARGIN, 5'd0);
    cfg_valid <= 1'b0;
    cell_queue = '{15'd0, 15'd1201, 15'd16897};
    wait_drained();
    // Largest window, largest nominal margin, and writes to unused indexes.
    write_reg(CCN_REG_WINDOW_SIZE, 5'd7);
    write_reg(CCN_REG_EDGE_MARGIN, 5'd24);
    write_reg(REG_SPARE_LOW, 5'h15);
    write_reg(REG_SPARE_HIGH, 5'h0a);
    cfg_valid <= 1'b0;
    cell_queue = '{15'd12700, 15'd17663};

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      write_reg(CCN_REG_WINDOW_SIZE, 5'($urandom_range(0, 31)));
      write_reg(CCN_REG_EDGE_MARGIN,
                5'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 31)
                                               : $urandom_range(0, 4)));
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_LOW : REG_SPARE_HIGH,
                  5'($urandom_range(0, 31)));
      end
      cfg_valid <= 1'b0;
      // Hold the output off long enough for the block to back up to its input.
      if (ph == 2) hold_request = 1'b1;
      repeat (CELLS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0: pick = 15'($urandom_range(CCN_NUM_CELLS, 32767));
          1: pick = 15'(($urandom_range(0, CCN_NUM_CELLS - 1) / CCN_NARROW_CELLS)
                        * CCN_NARROW_CELLS + $urandom_range(0, 1));
          default: pick = 15'($urandom_range(0, CCN_NUM_CELLS - 1));
        endcase
        cell_queue = {cell_queue, pick};
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_cells.size() != 0) begin
      $error("%0d expected results never arrived", expected_cells.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
